// ===== src/spd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_pkg: shared types and codes of the serial packet deframer
// Register indexes, result status codes and the configuration bundle.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned LimitW    = 6;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned ApbAddrW  = 5;

  localparam logic [CfgIdxW-1:0] REG_HEADER = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ACK    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_NAK    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_IAM    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LIMIT  = 3'd4;

  localparam logic [ByteW-1:0]  RST_HEADER = 8'd170;
  localparam logic [ByteW-1:0]  RST_ACK    = 8'd6;
  localparam logic [ByteW-1:0]  RST_NAK    = 8'd21;
  localparam logic [ByteW-1:0]  RST_IAM    = 8'd5;
  localparam logic [LimitW-1:0] RST_LIMIT  = 6'd32;

  typedef enum logic [2:0] {
    STATUS_INPROC   = 3'd0,
    STATUS_PACKET   = 3'd1,
    STATUS_CSUM_ERR = 3'd2,
    STATUS_SIZE_ERR = 3'd3,
    STATUS_ACK      = 3'd4,
    STATUS_NAK      = 3'd5,
    STATUS_IAM      = 3'd6
  } spd_status_e;

  typedef struct packed {
    logic [ByteW-1:0]  header_byte;
    logic [ByteW-1:0]  ack_byte;
    logic [ByteW-1:0]  nak_byte;
    logic [ByteW-1:0]  iam_byte;
    logic [LimitW-1:0] payload_limit;
  } spd_cfg_t;

endpackage

// ===== src/spd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds
// its value while no read is requested.
// ----------------------------------------------------------------------------
module spd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/spd_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_cfg: configuration registers of the serial packet deframer
// APB-style slave, no wait states; writes keep the low bits of each register.
// ----------------------------------------------------------------------------
module spd_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [spd_pkg::ApbAddrW-1:0]   paddr,
  input  logic [spd_pkg::ApbDataW-1:0]   pwdata,
  output logic [spd_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready,
  output spd_pkg::spd_cfg_t              cfg_o
);
  import spd_pkg::*;

  spd_cfg_t          cfg_q, cfg_d;
  logic [CfgIdxW-1:0] idx;
  logic               wr_en;

  assign idx    = paddr[ApbAddrW-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_HEADER: cfg_d.header_byte   = pwdata[ByteW-1:0];
        REG_ACK:    cfg_d.ack_byte      = pwdata[ByteW-1:0];
        REG_NAK:    cfg_d.nak_byte      = pwdata[ByteW-1:0];
        REG_IAM:    cfg_d.iam_byte      = pwdata[ByteW-1:0];
        REG_LIMIT:  cfg_d.payload_limit = pwdata[LimitW-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HEADER: prdata = {{(ApbDataW-ByteW){1'b0}}, cfg_q.header_byte};
      REG_ACK:    prdata = {{(ApbDataW-ByteW){1'b0}}, cfg_q.ack_byte};
      REG_NAK:    prdata = {{(ApbDataW-ByteW){1'b0}}, cfg_q.nak_byte};
      REG_IAM:    prdata = {{(ApbDataW-ByteW){1'b0}}, cfg_q.iam_byte};
      REG_LIMIT:  prdata = {{(ApbDataW-LimitW){1'b0}}, cfg_q.payload_limit};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte   <= RST_HEADER;
      cfg_q.ack_byte      <= RST_ACK;
      cfg_q.nak_byte      <= RST_NAK;
      cfg_q.iam_byte      <= RST_IAM;
      cfg_q.payload_limit <= RST_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/serial_packet_deframer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_packet_deframer_top: length-prefixed packet deframer
// Parses header, length, payload and XOR checksum from a byte stream and reports ACK, NAK and IAM bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, rx_byte_i) takes one received
//   byte per beat. Output channel (out_valid_o/out_ready_i) delivers result
//   beats of status_o, out_byte_o and last_o; last_o marks the final beat
//   caused by one input byte.
//   Every input byte except a packet's correct checksum causes exactly one
//   result beat, registered in the cycle after the input beat. Such a byte
//   does not hold the input: the next byte is taken while that result still
//   waits, provided the output register is free or being emptied.
//   A correct checksum replays the whole stored packet (length + 3 beats,
//   header to checksum) from the packet RAM: the first read is started as the
//   checksum is taken, then one beat per cycle follows through the RAM's single
//   read port while the output register is free or being emptied. No input is
//   taken until the final beat has been loaded.
//   When the receiver stalls, the output register holds its beat and the
//   block waits; nothing is dropped.
//   Reset returns the parser to waiting for a header, empties the output
//   register and restores the register defaults. The packet RAM is not
//   cleared; only bytes of the current packet are ever read back.
// ----------------------------------------------------------------------------
module serial_packet_deframer_top #(
  parameter int unsigned MAX_PAYLOAD_LEN = 61
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic [7:0]                    out_byte_o,
  output logic                          last_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spd_pkg::ApbAddrW-1:0]  paddr,
  input  logic [spd_pkg::ApbDataW-1:0]  pwdata,
  output logic [spd_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import spd_pkg::*;

  localparam int unsigned Depth = MAX_PAYLOAD_LEN + 3;
  localparam int unsigned AW    = $clog2(Depth);
  localparam logic [LimitW-1:0] MaxLimit = LimitW'(MAX_PAYLOAD_LEN);

  localparam logic [2:0] S_HDR  = 3'd0;
  localparam logic [2:0] S_LEN  = 3'd1;
  localparam logic [2:0] S_PLD  = 3'd2;
  localparam logic [2:0] S_CSM  = 3'd3;
  localparam logic [2:0] S_DUMP = 3'd4;

  spd_cfg_t cfg;

  logic [2:0]       state_q, state_d;
  logic [AW-1:0]    wpos_q, wpos_d;
  logic [AW-1:0]    len_q, len_d;
  logic [AW-1:0]    rd_idx_q, rd_idx_d;
  logic [ByteW-1:0] xor_q, xor_d;

  logic             out_valid_q, out_valid_d;
  spd_status_e      status_q, status_d;
  logic [ByteW-1:0] out_byte_q, out_byte_d;
  logic             last_q, last_d;

  logic             out_free;
  logic             in_fire;
  logic [LimitW-1:0] limit_eff;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [ByteW-1:0] ram_rdata;

  spd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  spd_ram #(
    .WIDTH (ByteW),
    .DEPTH (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rx_byte_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q != S_DUMP) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign limit_eff  = (cfg.payload_limit > MaxLimit) ? MaxLimit : cfg.payload_limit;

  always_comb begin
    state_d     = state_q;
    wpos_d      = wpos_q;
    len_d       = len_q;
    rd_idx_d    = rd_idx_q;
    xor_d       = xor_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    out_byte_d  = out_byte_q;
    last_d      = last_q;
    ram_we      = 1'b0;
    ram_waddr   = wpos_q;
    ram_re      = 1'b0;
    ram_raddr   = rd_idx_q;

    if (in_fire) begin
      // Default single-beat result; the checksum case may override it.
      out_valid_d = 1'b1;
      status_d    = STATUS_INPROC;
      out_byte_d  = '0;
      last_d      = 1'b1;
      case (state_q)
        S_HDR: begin
          if (rx_byte_i == cfg.header_byte) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            state_d   = S_LEN;
          end else if (rx_byte_i == cfg.ack_byte) begin
            status_d = STATUS_ACK;
          end else if (rx_byte_i == cfg.nak_byte) begin
            status_d = STATUS_NAK;
          end else if (rx_byte_i == cfg.iam_byte) begin
            status_d = STATUS_IAM;
          end
        end
        S_LEN: begin
          ram_we    = 1'b1;
          ram_waddr = AW'(1);
          if (rx_byte_i > {{(ByteW-LimitW){1'b0}}, limit_eff}) begin
            status_d = STATUS_SIZE_ERR;
            state_d  = S_HDR;
          end else begin
            len_d   = rx_byte_i[AW-1:0];
            wpos_d  = AW'(2);
            xor_d   = '0;
            state_d = (rx_byte_i == '0) ? S_CSM : S_PLD;
          end
        end
        S_PLD: begin
          ram_we = 1'b1;
          wpos_d = wpos_q + AW'(1);
          xor_d  = xor_q ^ rx_byte_i;
          if (wpos_q + AW'(1) == len_q + AW'(2)) begin
            state_d = S_CSM;
          end
        end
        S_CSM: begin
          ram_we = 1'b1;
          if (rx_byte_i != xor_q) begin
            status_d = STATUS_CSUM_ERR;
            state_d  = S_HDR;
          end else begin
            // Start the replay: fetch the header while the checksum lands.
            out_valid_d = out_valid_q && !out_ready_i;
            ram_re      = 1'b1;
            ram_raddr   = '0;
            rd_idx_d    = '0;
            state_d     = S_DUMP;
          end
        end
        default: state_d = S_HDR;
      endcase
    end else if (state_q == S_DUMP && out_free) begin
      out_valid_d = 1'b1;
      status_d    = STATUS_PACKET;
      out_byte_d  = ram_rdata;
      // The checksum sits at the final write position, so it ends the replay.
      last_d      = (rd_idx_q == wpos_q);
      if (rd_idx_q == wpos_q) begin
        state_d = S_HDR;
      end else begin
        rd_idx_d  = rd_idx_q + AW'(1);
        ram_re    = 1'b1;
        ram_raddr = rd_idx_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_HDR;
      wpos_q      <= '0;
      len_q       <= '0;
      rd_idx_q    <= '0;
      xor_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wpos_q      <= wpos_d;
      len_q       <= len_d;
      rd_idx_q    <= rd_idx_d;
      xor_q       <= xor_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

  // Every accepted byte either leaves a pending result or starts a replay.
  a_in_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (out_valid_q || state_q == S_DUMP))
    else $error("accepted byte produced no result");

  // Results other than packet bytes are single beats with a zero byte.
  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STATUS_PACKET) |-> (last_o && out_byte_o == '0))
    else $error("non-packet result is not a single zero beat");

  // A replay ends with its last beat and then the parser is idle again.
  a_replay_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP && out_free && rd_idx_q == wpos_q) |=>
      (state_q == S_HDR && last_o && status_o == STATUS_PACKET))
    else $error("replay did not end on the checksum beat");

  // The read index never passes the stored checksum during a replay.
  a_replay_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |-> (rd_idx_q <= wpos_q))
    else $error("replay read index past end of packet");

endmodule
